// ===== rtl/core/mlpq_pkg.sv =====
// Shared constants, payload types and codes of the multilevel priority queue.
package mlpq_pkg;

    localparam int LEVELS      = 8;
    localparam int LEVEL_DEPTH = 16;
    localparam int ID_BITS     = 16;

    localparam int LVL_W  = $clog2(LEVELS);
    localparam int IDX_W  = $clog2(LEVEL_DEPTH);
    localparam int OCC_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int TOT_W  = $clog2(LEVELS * LEVEL_DEPTH + 1);
    localparam int STORE_DEPTH = LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    // Width that holds both a 4-bit level number and the level count.
    localparam int CMP_W  = 6;

    localparam logic [3:0] LEVELS_RESET = 4'd8;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_PEEK   = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_BAD_PRIO = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WAIT = 1'b1
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  priority_req;
        logic [15:0] task_id;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [3:0]  found_priority;
        logic [15:0] found_id;
        logic [7:0]  total_count;
        logic        all_empty;
        logic [4:0]  level_count;
    } t_rsp;

    // Outcome of one request as decided by the level controller.
    typedef struct packed {
        t_status           status;
        logic [3:0]        found_priority;
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        total_count;
        logic              all_empty;
        logic [4:0]        level_count;
    } t_dec;

endpackage

// ===== rtl/core/mlpq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mlpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/mlpq_level_ctrl.sv =====
// Per-level head pointers and fill counts, the level search and the request decision.
module mlpq_level_ctrl
    import mlpq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_req             i_req,
    input  logic [CMP_W-1:0] i_act,
    input  logic             i_accept,
    output t_dec             o_dec
);

    logic [IDX_W-1:0] r_head [LEVELS];
    logic [OCC_W-1:0] r_occ  [LEVELS];
    logic [TOT_W-1:0] r_total;

    logic [CMP_W-1:0] prio_ext;
    logic             bad;
    logic [LVL_W-1:0] pidx;
    logic [OCC_W-1:0] occ_p;
    logic             is_add;
    logic             is_rm;
    logic             full;
    logic             hit;
    logic [LVL_W-1:0] fidx;
    logic [IDX_W:0]   slot_sum;
    logic [IDX_W-1:0] wr_slot;
    logic [IDX_W-1:0] head_next;
    logic             do_add;
    logic             do_rm;
    logic             do_rd;
    logic [OCC_W-1:0] lcount;
    logic [TOT_W-1:0] total_next;

    function automatic logic [4:0] sat_level(input logic [OCC_W-1:0] v);
        sat_level = (32'(v) > 32'd31) ? 5'd31 : 5'(v);
    endfunction

    function automatic logic [7:0] sat_total(input logic [TOT_W-1:0] v);
        sat_total = (32'(v) > 32'd255) ? 8'd255 : 8'(v);
    endfunction

    always_comb begin
        prio_ext = CMP_W'(i_req.priority_req);
        bad      = (prio_ext == '0) || (prio_ext > i_act);
        pidx     = LVL_W'(prio_ext - CMP_W'(1));
        occ_p    = r_occ[pidx];
        is_add   = (i_req.kind == KIND_ADD);
        is_rm    = (i_req.kind == KIND_REMOVE);
        full     = (32'(occ_p) >= 32'(LEVEL_DEPTH));

        // First active level that holds a task; level 1 wins.
        hit  = 1'b0;
        fidx = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (!hit && (CMP_W'(i) < i_act) && (r_occ[i] != '0)) begin
                hit  = 1'b1;
                fidx = LVL_W'(i);
            end
        end

        // Tail slot of the requested level, wrapped once.
        slot_sum = {1'b0, r_head[pidx]} + (IDX_W+1)'(occ_p);
        if (32'(slot_sum) >= 32'(LEVEL_DEPTH)) begin
            wr_slot = IDX_W'(32'(slot_sum) - 32'(LEVEL_DEPTH));
        end else begin
            wr_slot = IDX_W'(slot_sum);
        end

        if (32'(r_head[fidx]) == 32'(LEVEL_DEPTH - 1)) begin
            head_next = '0;
        end else begin
            head_next = r_head[fidx] + IDX_W'(1);
        end

        do_add = !bad && is_add && !full;
        do_rd  = !bad && !is_add && hit;
        do_rm  = do_rd && is_rm;

        lcount = occ_p;
        if (do_add) begin
            lcount = occ_p + OCC_W'(1);
        end else if (do_rm && (fidx == pidx)) begin
            lcount = occ_p - OCC_W'(1);
        end
        if (bad) begin
            lcount = '0;
        end

        total_next = r_total;
        if (do_add) begin
            total_next = r_total + TOT_W'(1);
        end else if (do_rm && (r_total != '0)) begin
            total_next = r_total - TOT_W'(1);
        end

        if (bad) begin
            o_dec.status = ST_BAD_PRIO;
        end else if (is_add) begin
            o_dec.status = full ? ST_FULL : ST_OK;
        end else begin
            o_dec.status = hit ? ST_OK : ST_EMPTY;
        end
        o_dec.found_priority = do_rd ? 4'(CMP_W'(fidx) + CMP_W'(1)) : 4'd0;
        o_dec.rd_en          = do_rd;
        o_dec.wr_en          = do_add;
        if (is_add) begin
            o_dec.addr = ADDR_W'(32'(pidx) * LEVEL_DEPTH + 32'(wr_slot));
        end else begin
            o_dec.addr = ADDR_W'(32'(fidx) * LEVEL_DEPTH + 32'(r_head[fidx]));
        end
        o_dec.total_count = sat_total(total_next);
        o_dec.all_empty   = (total_next == '0);
        o_dec.level_count = sat_level(lcount);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= '0;
                r_occ[i]  <= '0;
            end
            r_total <= '0;
        end else if (i_accept) begin
            if (do_add) begin
                r_occ[pidx] <= occ_p + OCC_W'(1);
            end
            if (do_rm) begin
                r_occ[fidx]  <= r_occ[fidx] - OCC_W'(1);
                r_head[fidx] <= head_next;
            end
            r_total <= total_next;
        end
    end

endmodule

// ===== rtl/core/multi_level_priority_queue_unit.sv =====
// Top level of the multilevel priority queue: request handshake, task memory and result register.
// An accepted request reads the task memory, then its result loads into the result register.
// A new request is not taken until the result of the previous one has been loaded.
// A result that waits in the output register keeps the following request in the memory wait.
// Reset (synchronous, active low) empties every level and sets the level count to eight.
// The task memory itself is not cleared; only entries that were written are ever read.
module multi_level_priority_queue_unit
    import mlpq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_stall,
    input  t_req       i_req,
    output logic       o_rsp_valid,
    input  logic       i_rsp_stall,
    output t_rsp       o_rsp,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data
);

    // Number of active levels, written by the configuration port.
    logic [3:0]       r_levels;
    logic [CMP_W-1:0] lev_ext;
    logic [CMP_W-1:0] act;

    t_state r_state;
    t_state n_state;

    logic accept;
    t_dec dec;

    // Result fields known at accept time, held while the memory read completes.
    t_dec r_pend;

    logic [ID_BITS-1:0] rdata;

    t_rsp r_rsp;
    logic r_rsp_valid;
    logic load_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= LEVELS_RESET;
        end else if (i_cfg_we) begin
            r_levels <= i_cfg_data;
        end
    end

    // The active count is the written value clamped to the number of levels built.
    assign lev_ext = CMP_W'(r_levels);
    assign act     = (lev_ext > CMP_W'(LEVELS)) ? CMP_W'(LEVELS) : lev_ext;

    // Requests are taken only while no other request is in flight.
    assign o_req_stall = (r_state != S_IDLE);
    assign accept      = i_req_valid && (r_state == S_IDLE);

    mlpq_level_ctrl u_level_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_act    (act),
        .i_accept (accept),
        .o_dec    (dec)
    );

    // An add writes the tail slot; a peek or remove reads the head slot. Never both.
    mlpq_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (accept && dec.wr_en),
        .i_waddr (dec.addr),
        .i_wdata (ID_BITS'(i_req.task_id)),
        .i_re    (accept && dec.rd_en),
        .i_raddr (dec.addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= dec;
        end
    end

    // The result register loads once the memory data is in, as long as it is free
    // or its current result leaves in this cycle.
    assign load_rsp = (r_state == S_WAIT) && (!r_rsp_valid || !i_rsp_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (load_rsp) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (load_rsp) begin
            r_rsp_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_rsp) begin
            r_rsp.status         <= r_pend.status;
            r_rsp.found_priority <= r_pend.found_priority;
            r_rsp.found_id       <= r_pend.rd_en ? 16'(rdata) : 16'd0;
            r_rsp.total_count    <= r_pend.total_count;
            r_rsp.all_empty      <= r_pend.all_empty;
            r_rsp.level_count    <= r_pend.level_count;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_accept_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_WAIT))
        else $error("accepted request did not move to the memory wait state");

    a_ram_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !(dec.rd_en && dec.wr_en))
        else $error("task memory read and write in the same cycle");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.all_empty == (o_rsp.total_count == 8'd0)))
        else $error("all-empty flag disagrees with total count");

    a_bad_prio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_rsp.status == ST_BAD_PRIO)) |->
            ((o_rsp.found_priority == 4'd0) && (o_rsp.level_count == 5'd0)))
        else $error("bad priority result carries a level");

    a_no_head_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_rsp.found_priority == 4'd0)) |-> (o_rsp.found_id == 16'd0))
        else $error("task id reported without a level");

endmodule
